@@ hw/rtl/hough_accumulator_2d_assert.svh @@
// ----------------------------------------------------------------------------
// hough_accumulator_2d_assert
// Assertion macros shared by the accumulator modules.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HOUGH_ACCUMULATOR_2D_ASSERT_SVH
`define HOUGH_ACCUMULATOR_2D_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hacc_pkg.sv @@
// ----------------------------------------------------------------------------
// hacc_pkg
// Types, operation codes and fixed field widths of the Hough accumulator.
// ----------------------------------------------------------------------------
package hacc_pkg;

  localparam int FUNC_W    = 3;
  localparam int IDX_W     = 6;
  localparam int AMT_W     = 16;
  localparam int OUT_W     = 16;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Operation codes carried by the func field.
  localparam logic [FUNC_W-1:0] FUNC_VOTE  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MAX   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_MAXRES
  } state_e;

  // Source of the memory read address.
  typedef enum logic [1:0] {
    RD_IN,
    RD_SCAN,
    RD_HELD
  } rd_src_e;

  typedef struct packed {
    logic    take;
    logic    scan_start;
    logic    scan_step;
    logic    upd_wr;
    logic    clr_start;
    logic    clr_wr;
    logic    load_rd;
    logic    load_max;
    rd_src_e rd_src;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/hough_accumulator_2d.sv @@
// ----------------------------------------------------------------------------
// hough_accumulator_2d
// Vote and subtract pass through the idle and update states; a read waits in the read state
// until the result register is free. Find max scans the cells in use, drains the compare stage
// and loads its result once the result register is free. Clear sweeps all ROWS*COLS cells.
// After reset a clearing pass over all ROWS*COLS cells zeroes the grid with in_ready_o low.
// Both dimension registers reset to 64. A new operation is taken only in the idle state.
// ----------------------------------------------------------------------------
module hough_accumulator_2d import hacc_pkg::*; #(
  parameter int ROWS        = 64,
  parameter int COLS        = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // Operation channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [IDX_W-1:0]     row_index_i,
  input  logic [IDX_W-1:0]     col_index_i,
  input  logic [AMT_W-1:0]     amount_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_W-1:0]     count_value_o,
  output logic [IDX_W-1:0]     max_row_o,
  output logic [IDX_W-1:0]     max_col_o
);

  // The controller only sees the operation code and a few status flags; every
  // address, count and compare lives in the datapath. Each operation is taken
  // in the idle state, where the memory read for the addressed cell is issued
  // in the same cycle as the transfer. Vote and subtract write the modified
  // cell back on the next cycle. A read waits in its own state until the result
  // register is free, so a finished result never blocks the following transfer
  // for longer than the downstream side holds it.
  cmd_t    cmd;
  status_t status;

  hacc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Find max walks the cells in use row-major, one read per cycle, with a
  // registered compare stage behind the memory; the strict compare keeps the
  // first of several equal maxima. Clear sweeps every cell of the grid.
  hacc_datapath #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .func_i        (func_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .amount_i      (amount_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .count_value_o (count_value_o),
    .max_row_o     (max_row_o),
    .max_col_o     (max_col_o)
  );

endmodule

@@ hw/rtl/hacc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hacc_ctrl
// Sequencer of the accumulator: decodes each operation and steps the datapath.
// ----------------------------------------------------------------------------
`include "hough_accumulator_2d_assert.svh"

module hacc_ctrl import hacc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [FUNC_W-1:0] func_i,
  output logic              in_ready_o,
  input  status_t           status_i,
  output cmd_t              cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            FUNC_VOTE:  state_d = ST_UPDATE;
            FUNC_SUB:   state_d = ST_UPDATE;
            FUNC_READ:  state_d = ST_READ;
            FUNC_MAX:   state_d = ST_SCAN;
            FUNC_CLEAR: state_d = ST_CLEAR;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      ST_READ: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (status_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_MAXRES;
      ST_MAXRES: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cmd_o      = '0;
    cmd_o.rd_src = RD_HELD;
    case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        cmd_o.rd_src = RD_IN;
        if (in_valid_i) begin
          cmd_o.take       = 1'b1;
          cmd_o.scan_start = (func_i == FUNC_MAX);
          cmd_o.clr_start  = (func_i == FUNC_CLEAR);
        end
      end
      ST_UPDATE: cmd_o.upd_wr = 1'b1;
      ST_READ:   cmd_o.load_rd = status_i.out_free;
      ST_SCAN: begin
        cmd_o.rd_src    = RD_SCAN;
        cmd_o.scan_step = 1'b1;
      end
      ST_MAXRES: cmd_o.load_max = status_i.out_free;
      default: cmd_o.rd_src = RD_HELD;
    endcase
  end

  `HA_ASSERT_NEXT(a_read_goes_read, in_valid_i && in_ready_o && func_i == FUNC_READ, state_q == ST_READ, "accepted read did not enter the read state")
  `HA_ASSERT_NEXT(a_scan_to_drain, state_q == ST_SCAN && status_i.scan_last, state_q == ST_DRAIN, "scan did not stop after its last cell")

endmodule

@@ hw/rtl/hacc_datapath.sv @@
// ----------------------------------------------------------------------------
// hacc_datapath
// Vote memory, item registers, scan and clear counters, and result register.
// ----------------------------------------------------------------------------
`include "hough_accumulator_2d_assert.svh"

module hacc_datapath import hacc_pkg::*; #(
  parameter int ROWS        = 64,
  parameter int COLS        = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [IDX_W-1:0]     row_index_i,
  input  logic [IDX_W-1:0]     col_index_i,
  input  logic [AMT_W-1:0]     amount_i,
  input  logic                 out_ready_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  output logic                 out_valid_o,
  output logic [OUT_W-1:0]     count_value_o,
  output logic [IDX_W-1:0]     max_row_o,
  output logic [IDX_W-1:0]     max_col_o
);

  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RW     = $clog2(ROWS);
  localparam int CLW    = $clog2(COLS);
  localparam int RDW    = $clog2(ROWS + 1);
  localparam int CDW    = $clog2(COLS + 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [CFG_W-1:0] rows_used_q, cols_used_q;
  logic [RDW-1:0]   nr;
  logic [CDW-1:0]   nc;

  logic                   inside_in, inside_q;
  logic [ADDR_W-1:0]      in_addr, scan_addr, rd_addr, addr_q, wr_addr, clr_addr_q;
  logic [FUNC_W-1:0]      func_q;
  logic [IDX_W-1:0]       row_q, col_q;
  logic [AMT_W-1:0]       amt_q;
  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata_q, upd_val, wr_data;
  logic                   mem_we;

  logic [RW-1:0]          sr_q, pr_q, br_q;
  logic [CLW-1:0]         sc_q, pc_q, bc_q;
  logic                   pv_q, col_last;
  logic [COUNT_WIDTH-1:0] best_q;

  logic                   out_valid_q, out_free;
  logic [OUT_W-1:0]       cnt_q;
  logic [IDX_W-1:0]       orow_q, ocol_q;

  // Register values out of range are clamped to the grid.
  always_comb begin
    if (rows_used_q == '0) begin
      nr = RDW'(1);
    end else if (32'(rows_used_q) > ROWS) begin
      nr = RDW'(ROWS);
    end else begin
      nr = RDW'(rows_used_q);
    end
    if (cols_used_q == '0) begin
      nc = CDW'(1);
    end else if (32'(cols_used_q) > COLS) begin
      nc = CDW'(COLS);
    end else begin
      nc = CDW'(cols_used_q);
    end
  end

  assign inside_in = (32'(row_index_i) < 32'(nr)) && (32'(col_index_i) < 32'(nc));
  assign in_addr   = inside_in ? ADDR_W'(32'(row_index_i) * COLS + 32'(col_index_i)) : '0;
  assign scan_addr = ADDR_W'(32'(sr_q) * COLS + 32'(sc_q));

  always_comb begin
    case (cmd_i.rd_src)
      RD_IN:   rd_addr = in_addr;
      RD_SCAN: rd_addr = scan_addr;
      default: rd_addr = addr_q;
    endcase
  end

  always_comb begin
    if (func_q == FUNC_VOTE) begin
      upd_val = (rdata_q == CNT_MAX) ? rdata_q : rdata_q + COUNT_WIDTH'(1);
    end else begin
      upd_val = rdata_q - COUNT_WIDTH'(amt_q);
    end
  end

  assign mem_we  = cmd_i.clr_wr || (cmd_i.upd_wr && inside_q);
  assign wr_addr = cmd_i.clr_wr ? clr_addr_q : addr_q;
  assign wr_data = cmd_i.clr_wr ? '0 : upd_val;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      func_q   <= func_i;
      row_q    <= row_index_i;
      col_q    <= col_index_i;
      amt_q    <= amount_i;
      addr_q   <= in_addr;
      inside_q <= inside_in;
    end
  end

  assign col_last = (32'(sc_q) == 32'(nc) - 32'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_used_q <= CFG_DIM_RESET;
      cols_used_q <= CFG_DIM_RESET;
      clr_addr_q  <= '0;
      sr_q        <= '0;
      sc_q        <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS_USED: rows_used_q <= cfg_wdata_i;
          CFG_COLS_USED: cols_used_q <= cfg_wdata_i;
          default: rows_used_q <= rows_used_q;
        endcase
      end
      if (cmd_i.clr_start) begin
        clr_addr_q <= '0;
      end else if (cmd_i.clr_wr) begin
        clr_addr_q <= status_o.clr_last ? '0 : clr_addr_q + ADDR_W'(1);
      end
      if (cmd_i.scan_start) begin
        sr_q <= '0;
        sc_q <= '0;
      end else if (cmd_i.scan_step) begin
        if (col_last) begin
          sc_q <= '0;
          sr_q <= sr_q + RW'(1);
        end else begin
          sc_q <= sc_q + CLW'(1);
        end
      end
      pv_q <= cmd_i.scan_step;
      if (cmd_i.load_rd || cmd_i.load_max) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Compare stage: the data read for the previous scan position is checked here.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      pr_q <= sr_q;
      pc_q <= sc_q;
    end
    if (cmd_i.scan_start) begin
      best_q <= '0;
      br_q   <= '0;
      bc_q   <= '0;
    end else if (pv_q && (rdata_q > best_q)) begin
      best_q <= rdata_q;
      br_q   <= pr_q;
      bc_q   <= pc_q;
    end
    if (cmd_i.load_rd) begin
      cnt_q  <= inside_q ? OUT_W'(rdata_q) : '0;
      orow_q <= row_q;
      ocol_q <= col_q;
    end else if (cmd_i.load_max) begin
      cnt_q  <= OUT_W'(best_q);
      orow_q <= IDX_W'(br_q);
      ocol_q <= IDX_W'(bc_q);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.clr_last  = (clr_addr_q == ADDR_W'(DEPTH - 1));
  assign status_o.scan_last = col_last && (32'(sr_q) == 32'(nr) - 32'd1);
  assign status_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign count_value_o = cnt_q;
  assign max_row_o     = orow_q;
  assign max_col_o     = ocol_q;

  `HA_ASSERT_NOW(a_load_when_free, cmd_i.load_rd || cmd_i.load_max, out_free, "result loaded over an untaken result")
  `HA_ASSERT_NOW(a_upd_after_take, cmd_i.upd_wr, $past(cmd_i.take), "cell update without a preceding item")

endmodule

@@ tb/hough_accumulator_2d_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// hough_accumulator_2d_tb_pkg
// Grid predictor and result scoreboard for the Hough accumulator testbench.
// The class keeps its own copy of the vote grid and the dimension registers.
// ----------------------------------------------------------------------------
package hough_accumulator_2d_tb_pkg;
  import hacc_pkg::*;

  localparam int unsigned GRID_ROWS = 64;
  localparam int unsigned GRID_COLS = 64;
  localparam int unsigned COUNT_W   = 16;

  typedef struct packed {
    logic [OUT_W-1:0] count_value;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cell_report_t;

  // A dimension register of zero acts as one, and values past the grid act as the grid size.
  function automatic int unsigned span_in_use(logic [CFG_W-1:0] reg_value, int unsigned limit);
    if (reg_value == '0) return 1;
    if (32'(reg_value) > limit) return limit;
    return 32'(reg_value);
  endfunction

  class vote_grid_model;
    logic [COUNT_W-1:0] cells [GRID_ROWS*GRID_COLS];
    logic [CFG_W-1:0]   rows_reg;
    logic [CFG_W-1:0]   cols_reg;
    cell_report_t       pending_reports [$];
    int unsigned        mismatches;
    int unsigned        reports_checked;

    function new();
      foreach (cells[i]) cells[i] = '0;
      rows_reg        = CFG_DIM_RESET;
      cols_reg        = CFG_DIM_RESET;
      mismatches      = 0;
      reports_checked = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_ROWS_USED: rows_reg = value;
        CFG_COLS_USED: cols_reg = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending_count();
      return pending_reports.size();
    endfunction

    // Updates the grid for one accepted operation and queues the result it causes.
    function void apply_op(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic [AMT_W-1:0] amount);
      int unsigned        nr;
      int unsigned        nc;
      int unsigned        addr;
      bit                 in_use;
      logic [COUNT_W-1:0] best;
      cell_report_t       rep;
      nr     = span_in_use(rows_reg, GRID_ROWS);
      nc     = span_in_use(cols_reg, GRID_COLS);
      in_use = (row < nr) && (col < nc);
      addr   = row * GRID_COLS + col;
      case (func)
        FUNC_VOTE: begin
          if (in_use && cells[addr] != '1) cells[addr] = cells[addr] + 1'b1;
        end
        FUNC_READ: begin
          rep.count_value = in_use ? OUT_W'(cells[addr]) : '0;
          rep.row         = row;
          rep.col         = col;
          pending_reports = {pending_reports, rep};
        end
        FUNC_SUB: begin
          if (in_use) cells[addr] = cells[addr] - COUNT_W'(amount);
        end
        FUNC_MAX: begin
          // Row-major scan; only a strictly greater count moves the winner.
          best    = '0;
          rep.row = '0;
          rep.col = '0;
          for (int unsigned i = 0; i < nr; i++) begin
            for (int unsigned j = 0; j < nc; j++) begin
              if (cells[i*GRID_COLS + j] > best) begin
                best    = cells[i*GRID_COLS + j];
                rep.row = IDX_W'(i);
                rep.col = IDX_W'(j);
              end
            end
          end
          rep.count_value = OUT_W'(best);
          pending_reports = {pending_reports, rep};
        end
        FUNC_CLEAR: begin
          foreach (cells[i]) cells[i] = '0;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("ERROR %0t: %s expected %0d, got %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(cell_report_t got);
      cell_report_t want;
      reports_checked++;
      if (pending_reports.size() == 0) begin
        $display("ERROR %0t: result with nothing pending, expected none, got count %0d at (%0d,%0d)",
                 $time, got.count_value, got.row, got.col);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("count_value", 32'(want.count_value), 32'(got.count_value));
      compare_field("max_row", 32'(want.row), 32'(got.row));
      compare_field("max_col", 32'(want.col), 32'(got.col));
    endfunction
  endclass

endpackage

@@ tb/hough_accumulator_2d_tb.sv @@
// ----------------------------------------------------------------------------
// hough_accumulator_2d_tb
// Self-checking bench for the Hough vote accumulator. A directed sequence
// covers saturation, wrapping subtraction, ties and the empty-grid scan, then
// random operations run under ten dimension settings with random flow control
// on both channels. Every result is compared against a predicted grid.
// ----------------------------------------------------------------------------
module hough_accumulator_2d_tb;
  import hacc_pkg::*;
  import hough_accumulator_2d_tb_pkg::*;

  localparam int unsigned CLK_PERIOD       = 4;
  // A clear or a full-grid scan is the longest thing the block can be busy with.
  localparam int unsigned SETTLE_CYCLES    = GRID_ROWS * GRID_COLS + 32;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned TIMEOUT_CYCLES   = 2_000_000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [FUNC_W-1:0]    func_i      = '0;
  logic [IDX_W-1:0]     row_index_i = '0;
  logic [IDX_W-1:0]     col_index_i = '0;
  logic [AMT_W-1:0]     amount_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [OUT_W-1:0]     count_value_o;
  logic [IDX_W-1:0]     max_row_o;
  logic [IDX_W-1:0]     max_col_o;

  vote_grid_model grid;

  // While calm is set neither side inserts gaps, so operations are offered without pause.
  bit          calm;
  // Set by the stimulus in the middle of a busy phase; the result side then
  // holds off for a long stretch so the block backs up and stalls its input.
  bit          hold_request;
  int unsigned ops_sent;
  int unsigned scans_sent;
  int unsigned clears_sent;
  int unsigned settings_run;

  hough_accumulator_2d #(
    .ROWS       (GRID_ROWS),
    .COLS       (GRID_COLS),
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .amount_i     (amount_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .count_value_o(count_value_o),
    .max_row_o    (max_row_o),
    .max_col_o    (max_col_o)
  );

  always begin
    #(CLK_PERIOD/2) clk_i = 1'b1;
    #(CLK_PERIOD/2) clk_i = 1'b0;
  end

  // Alternate between short calm stretches and longer stretches with idling.
  always begin
    calm = 1'b0;
    repeat ($urandom_range(300, 900)) @(posedge clk_i);
    calm = 1'b1;
    repeat ($urandom_range(100, 300)) @(posedge clk_i);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Half the indices land on a few hot cells so that counts build up and
  // reads and scans see them; a fifth fall anywhere, often outside the cells in use.
  function automatic logic [IDX_W-1:0] pick_index(int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return IDX_W'($urandom_range(0, ((span < 4) ? span : 4) - 1));
    if (r < 8) return IDX_W'($urandom_range(0, span - 1));
    return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
  endfunction

  function automatic logic [AMT_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return AMT_W'($urandom_range(0, 3));
    if (r < 85) return AMT_W'($urandom_range(0, (1 << AMT_W) - 1));
    return '1;
  endfunction

  // Offers one operation and waits for its transfer. Valid stays high when no
  // gap follows, so the next operation is offered right after the last one is taken.
  task automatic send_op(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] row,
                         logic [IDX_W-1:0] col, logic [AMT_W-1:0] amount,
                         int unsigned gap);
    in_valid_i  <= 1'b1;
    func_i      <= func;
    row_index_i <= row;
    col_index_i <= col;
    amount_i    <= amount;
    do @(posedge clk_i); while (!in_ready_o);
    grid.apply_op(func, row, col, amount);
    ops_sent++;
    if (func == FUNC_MAX) scans_sent++;
    if (func == FUNC_CLEAR) clears_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits for every pending result, then lets a possible clear or scan finish.
  task automatic drain_and_pause();
    in_valid_i <= 1'b0;
    while (grid.pending_count() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dimensions(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ROWS_USED;
    cfg_wdata_i <= rows;
    @(posedge clk_i);
    grid.set_register(CFG_ROWS_USED, rows);
    cfg_idx_i   <= CFG_COLS_USED;
    cfg_wdata_i <= cols;
    @(posedge clk_i);
    grid.set_register(CFG_COLS_USED, cols);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_random_phase(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                                  int unsigned count, bit with_hold);
    int unsigned       nr;
    int unsigned       nc;
    int unsigned       r;
    int unsigned       scan_pct;
    logic [FUNC_W-1:0] func;
    drain_and_pause();
    set_dimensions(rows, cols);
    settings_run++;
    nr = span_in_use(rows, GRID_ROWS);
    nc = span_in_use(cols, GRID_COLS);
    // A scan reads every cell in use, so large grids get few of them.
    scan_pct = (nr * nc <= 256) ? 8 : 1;
    for (int unsigned k = 0; k < count; k++) begin
      if (with_hold && k == count / 2) hold_request = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 2) func = FUNC_W'($urandom_range(int'(FUNC_CLEAR) + 1, (1 << FUNC_W) - 1));
      else if (r < 3) func = FUNC_CLEAR;
      else if (r < 3 + scan_pct) func = FUNC_MAX;
      else if (r < 55) func = FUNC_VOTE;
      else if (r < 80) func = FUNC_READ;
      else func = FUNC_SUB;
      send_op(func, pick_index(nr), pick_index(nc), pick_amount(), pick_gap(calm));
    end
  endtask

  // Result side: checks each transfer and drives ready with random stalls.
  initial begin : result_sink
    int unsigned  stall_left;
    cell_report_t got;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{count_value: count_value_o, row: max_row_o, col: max_col_o};
        grid.check_report(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD_CYCLES;
      end
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap(calm);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    grid = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset dimensions of 64 by 64. The first transfer
    // only happens once the clearing pass after reset is over.
    send_op(FUNC_MAX,   6'd0,  6'd0,  16'd0,    pick_gap(calm));  // empty grid scan
    send_op(FUNC_VOTE,  6'd0,  6'd0,  16'hFFFF, pick_gap(calm));
    send_op(FUNC_VOTE,  6'd63, 6'd63, 16'd0,    0);
    send_op(FUNC_VOTE,  6'd63, 6'd63, 16'd0,    0);
    send_op(FUNC_READ,  6'd63, 6'd63, 16'd0,    0);
    send_op(FUNC_READ,  6'd0,  6'd0,  16'd0,    pick_gap(calm));
    // Subtracting from zero wraps to the counter maximum; a vote must then saturate.
    send_op(FUNC_SUB,   6'd5,  6'd9,  16'd1,    0);
    send_op(FUNC_VOTE,  6'd5,  6'd9,  16'd0,    0);
    send_op(FUNC_READ,  6'd5,  6'd9,  16'd0,    pick_gap(calm));
    send_op(FUNC_SUB,   6'd63, 6'd63, 16'hFFFF, 0);
    send_op(FUNC_READ,  6'd63, 6'd63, 16'h5AA5, 0);
    send_op(FUNC_MAX,   6'd17, 6'd42, 16'd0,    pick_gap(calm));
    // An equal maximum earlier in row-major order must win the scan.
    send_op(FUNC_SUB,   6'd0,  6'd40, 16'd1,    0);
    send_op(FUNC_MAX,   6'd0,  6'd0,  16'd0,    0);
    // Unused operation codes must leave the grid alone.
    send_op(FUNC_W'(int'(FUNC_CLEAR) + 1), 6'd0,  6'd40, 16'hFFFF, 0);
    send_op(FUNC_W'(int'(FUNC_CLEAR) + 2), 6'd5,  6'd9,  16'h00FF, 0);
    send_op(FUNC_W'(int'(FUNC_CLEAR) + 3), 6'd63, 6'd63, 16'hFF00, 0);
    send_op(FUNC_READ,  6'd0,  6'd40, 16'd0,    pick_gap(calm));
    send_op(FUNC_CLEAR, 6'd33, 6'd12, 16'hA5A5, 0);
    send_op(FUNC_READ,  6'd5,  6'd9,  16'd0,    0);
    send_op(FUNC_MAX,   6'd0,  6'd0,  16'd0,    pick_gap(calm));

    // Random part. Register values of 0 and 127 exercise the clamping and
    // every bit of the write data; the grid carries over between settings.
    run_random_phase(7'd1,   7'd1,   100, 1'b0);
    run_random_phase(7'd64,  7'd64,  150, 1'b0);
    run_random_phase(7'd0,   7'd127, 100, 1'b0);
    run_random_phase(7'd127, 7'd0,   100, 1'b0);
    run_random_phase(7'd4,   7'd6,   200, 1'b0);
    run_random_phase(7'd8,   7'd8,   250, 1'b1);
    run_random_phase(7'd2,   7'd64,  150, 1'b0);
    run_random_phase(7'd64,  7'd3,   150, 1'b0);
    run_random_phase(7'd16,  7'd16,  200, 1'b1);
    run_random_phase(7'd127, 7'd127, 150, 1'b0);

    drain_and_pause();
    $display("Covered %0d operations (%0d scans, %0d clears) over %0d dimension settings,",
             ops_sent, scans_sent, clears_sent, settings_run);
    $display("with %0d results checked under random stalls on both channels.",
             grid.reports_checked);
    if (grid.mismatches == 0 && grid.pending_count() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("ERROR %0t: run did not finish, %0d results still pending",
             $time, grid.pending_count());
    $display("Mismatches found");
    $finish;
  end

endmodule
